@@ sv/pdt_pkg.sv @@
// ============================================================================
// pdt_pkg: shared types and constants of the piezo drum trigger
// Widths, register defaults, MIDI codes and the structs that pass between
// the sequencer, the velocity divider and the MIDI serializer.
// ============================================================================
package pdt_pkg;

    localparam int PAD_COUNT  = 6;
    localparam int NOTE_SLOTS = 6;

    localparam int PAD_W    = 3;
    localparam int SMP_W    = 10;
    localparam int TIME_W   = 32;
    localparam int DEB_W    = 16;
    localparam int NOTES_W  = 48;
    localparam int VEL_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 48;

    // Numerator of the velocity scale: sample * 127 fits in this many bits.
    localparam int NUM_W = SMP_W + VEL_W;
    localparam int QUO_W = VEL_W + 1;
    localparam int STEP_W = $clog2(QUO_W);

    localparam logic [SMP_W-1:0]   SENS_RESET  = 10'd120;
    localparam logic [SMP_W-1:0]   TRIG_RESET  = 10'd20;
    localparam logic [DEB_W-1:0]   DEB_RESET   = 16'd50;
    localparam logic [NOTES_W-1:0] NOTES_RESET = 48'h2439312F301F;

    localparam logic [BYTE_W-1:0] MIDI_NOTE_ON  = 8'h90;
    localparam logic [BYTE_W-1:0] MIDI_NOTE_OFF = 8'h80;
    localparam logic [VEL_W-1:0]  VEL_MAX       = 7'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS  = 2'd0,
        CFG_TRIG  = 2'd1,
        CFG_DEB   = 2'd2,
        CFG_NOTES = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_DIV  = 3'b100
    } t_state;

    typedef struct packed {
        logic             start;
        logic [SMP_W-1:0] sample;
        logic [SMP_W-1:0] span;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [VEL_W-1:0] vel;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [VEL_W-1:0] note;
        logic [VEL_W-1:0] peak;
    } t_tx_req;

endpackage

@@ sv/pdt_in_if.sv @@
// ============================================================================
// pdt_in_if: sample channel
// Carries one ADC word per handshake: pad index, sample and time stamp.
// ============================================================================
interface pdt_in_if;
    logic                        valid;
    logic                        ready;
    logic [pdt_pkg::PAD_W-1:0]   pad_index;
    logic [pdt_pkg::SMP_W-1:0]   sample;
    logic [pdt_pkg::TIME_W-1:0]  now_ms;

    modport source(output valid, pad_index, sample, now_ms, input ready);
    modport sink(input valid, pad_index, sample, now_ms, output ready);
endinterface

@@ sv/pdt_out_if.sv @@
// ============================================================================
// pdt_out_if: MIDI byte channel
// Carries one serial MIDI word per handshake and a flag on the last word.
// ============================================================================
interface pdt_out_if;
    logic                        valid;
    logic                        ready;
    logic [pdt_pkg::BYTE_W-1:0]  midi_byte;
    logic                        last_byte;

    modport source(output valid, midi_byte, last_byte, input ready);
    modport sink(input valid, midi_byte, last_byte, output ready);
endinterface

@@ sv/pdt_div.sv @@
// ============================================================================
// pdt_div: serial velocity divider
// Computes min(floor(sample * 127 / span), 127) with one compare and
// subtract per cycle.
// ============================================================================
module pdt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pdt_pkg::t_div_req i_req,
    output pdt_pkg::t_div_rsp o_rsp
);
    import pdt_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_dvs;
    logic [QUO_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic [VEL_W-1:0]  r_vel;

    logic              ge;
    logic [NUM_W-1:0]  n_rem;
    logic [QUO_W-1:0]  n_quo;

    always_comb begin
        ge    = (r_rem >= r_dvs);
        n_rem = ge ? (r_rem - r_dvs) : r_rem;
        n_quo = {r_quo[QUO_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // sample * 127 as (sample << 7) - sample.
            r_rem  <= {i_req.sample, {VEL_W{1'b0}}} - NUM_W'(i_req.sample);
            r_dvs  <= {i_req.span, {VEL_W{1'b0}}};
            r_quo  <= '0;
            r_step <= STEP_W'(QUO_W - 1);
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_dvs  <= r_dvs >> 1;
            r_quo  <= n_quo;
            r_step <= r_step - 1'b1;
            if (r_step == '0) begin
                r_vel <= n_quo[QUO_W-1] ? VEL_MAX : n_quo[VEL_W-1:0];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.vel  = r_vel;

endmodule

@@ sv/pdt_tx.sv @@
// ============================================================================
// pdt_tx: MIDI serializer
// Holds one note on/off pair and hands it out as six words, note on
// status, note, velocity, note off status, note, velocity.
// ============================================================================
module pdt_tx (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pdt_pkg::t_tx_req i_req,
    output logic             o_busy,
    pdt_out_if.source        o_midi
);
    import pdt_pkg::*;

    localparam logic [2:0] LAST_WORD = 3'd5;

    logic             r_valid;
    logic [2:0]       r_cnt;
    logic [VEL_W-1:0] r_note;
    logic [VEL_W-1:0] r_peak;
    logic             take;

    assign take = r_valid && o_midi.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_req.start) begin
            r_valid <= 1'b1;
            r_cnt   <= '0;
        end else if (take) begin
            if (r_cnt == LAST_WORD) begin
                r_valid <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_note <= i_req.note;
            r_peak <= i_req.peak;
        end
    end

    always_comb begin
        unique case (r_cnt)
            3'd0:    o_midi.midi_byte = MIDI_NOTE_ON;
            3'd1:    o_midi.midi_byte = {1'b0, r_note};
            3'd2:    o_midi.midi_byte = {1'b0, r_peak};
            3'd3:    o_midi.midi_byte = MIDI_NOTE_OFF;
            3'd4:    o_midi.midi_byte = {1'b0, r_note};
            3'd5:    o_midi.midi_byte = {1'b0, r_peak};
            default: o_midi.midi_byte = '0;
        endcase
    end

    assign o_midi.valid     = r_valid;
    assign o_midi.last_byte = (r_cnt == LAST_WORD);
    assign o_busy           = r_valid;

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_valid) |-> $past(r_cnt == LAST_WORD))
        else $error("serializer stopped before the sixth word");

endmodule

@@ sv/piezo_drum_trigger_top.sv @@
// ============================================================================
// piezo_drum_trigger_top: piezo pad trigger with MIDI output
// Turns per-pad ADC samples into note on/off pairs with peak velocity.
// ============================================================================
// Usage:
// Samples arrive on i_smp, one word per pad reading with a millisecond time
// stamp. MIDI words leave on o_midi, six per released hit, the sixth flagged
// by last_byte. Registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data; the user must do so only while the block is idle, since the
// block itself does not enforce it. A sample that starts or continues a hit
// while sensitivity is above the trigger level passes through capture, the
// pad lookup and eight iterations of the shared compare and subtract unit
// of the velocity divider, then the result, before the next sample can be
// accepted. Any other sample returns to idle after the lookup.
// A release hands its pair to the serializer in the lookup cycle; the words
// then leave at one per cycle while the receiver is ready.
// When the receiver stalls, the serializer holds its word and a sample is
// still accepted; only a further release waits in the lookup step until
// the previous pair has fully gone out.
// Reset clears every pad's state and loads the register defaults.
// ============================================================================
module piezo_drum_trigger_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pdt_in_if.sink                          i_smp,
    pdt_out_if.source                       o_midi,
    input  logic                            i_cfg_we,
    input  logic [pdt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pdt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pdt_pkg::*;

    t_state             r_state;
    logic [SMP_W-1:0]   r_sens;
    logic [SMP_W-1:0]   r_trig;
    logic [DEB_W-1:0]   r_deb;
    logic [NOTES_W-1:0] r_notes;

    logic [PAD_W-1:0]   r_pad;
    logic [SMP_W-1:0]   r_smp;
    logic [TIME_W-1:0]  r_now;

    logic [PAD_COUNT-1:0] r_playing;
    logic [VEL_W-1:0]     r_peak [PAD_COUNT];
    logic [TIME_W-1:0]    r_rel  [PAD_COUNT];

    t_div_req         div_req;
    t_div_rsp         div_rsp;
    t_tx_req          tx_req;
    logic             tx_busy;

    logic              accept;
    logic              pad_ok;
    logic              hit;
    logic              deb_ok;
    logic              span_empty;
    logic [TIME_W-1:0] elapsed;
    logic [VEL_W-1:0]  note;
    logic              do_start;
    logic              do_release;

    assign i_smp.ready = (r_state == ST_IDLE);
    assign accept      = i_smp.valid && i_smp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens  <= SENS_RESET;
            r_trig  <= TRIG_RESET;
            r_deb   <= DEB_RESET;
            r_notes <= NOTES_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SENS:  r_sens  <= i_cfg_data[SMP_W-1:0];
                CFG_TRIG:  r_trig  <= i_cfg_data[SMP_W-1:0];
                CFG_DEB:   r_deb   <= i_cfg_data[DEB_W-1:0];
                CFG_NOTES: r_notes <= i_cfg_data[NOTES_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pad <= i_smp.pad_index;
            r_smp <= i_smp.sample;
            r_now <= i_smp.now_ms;
        end
    end

    always_comb begin
        pad_ok     = (int'(r_pad) < PAD_COUNT);
        hit        = (r_smp >= r_trig);
        elapsed    = r_now - r_rel[r_pad];
        deb_ok     = (elapsed >= TIME_W'(r_deb));
        span_empty = (r_sens <= r_trig);
        if (int'(r_pad) < NOTE_SLOTS) begin
            note = r_notes[{r_pad, 3'b000} +: VEL_W];
        end else begin
            note = '0;
        end
        do_start   = (r_state == ST_LOAD) && pad_ok && hit
                     && (r_playing[r_pad] || deb_ok);
        do_release = (r_state == ST_LOAD) && pad_ok && !hit
                     && r_playing[r_pad] && !tx_busy;
    end

    assign div_req.start  = do_start && !span_empty;
    assign div_req.sample = r_smp;
    assign div_req.span   = r_sens - r_trig;

    assign tx_req.start = do_release;
    assign tx_req.note  = note;
    assign tx_req.peak  = r_peak[r_pad];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_playing <= '0;
            for (int p = 0; p < PAD_COUNT; p++) begin
                r_peak[p] <= '0;
                r_rel[p]  <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (do_start) begin
                        r_playing[r_pad] <= 1'b1;
                        if (span_empty) begin
                            r_peak[r_pad] <= VEL_MAX;
                            r_state       <= ST_IDLE;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end else if (do_release) begin
                        r_playing[r_pad] <= 1'b0;
                        r_peak[r_pad]    <= '0;
                        r_rel[r_pad]     <= r_now;
                        r_state          <= ST_IDLE;
                    end else if (!(pad_ok && !hit && r_playing[r_pad])) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        if (div_rsp.vel > r_peak[r_pad]) begin
                            r_peak[r_pad] <= div_rsp.vel;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    pdt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    pdt_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tx_req),
        .o_busy  (tx_busy),
        .o_midi  (o_midi)
    );

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV))
        else $error("velocity result outside the divide step");

    a_tx_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_req.start |-> !tx_busy)
        else $error("new MIDI pair while the serializer is busy");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_req.start |=> (!r_playing[r_pad] && (r_peak[r_pad] == '0)))
        else $error("released pad still playing");

endmodule
